[rtl/spq_pkg.sv]
package spq_pkg;

    localparam int DEPTH_DEF = 64;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_FIND   = 2'd2;
    localparam logic [1:0] KIND_REMOVE = 2'd3;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [15:0] f;
        logic [15:0] g;
        logic [15:0] h;
        logic [15:0] loc;
        logic [15:0] par;
        logic [7:0]  ob;
    } entry_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] cost_total;
        logic [15:0] cost_so_far;
        logic [15:0] cost_estimate;
        logic [15:0] location;
        logic [15:0] parent_location;
        logic [7:0]  obstacle_tag;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_cost_total;
        logic [15:0] out_cost_so_far;
        logic [15:0] out_cost_estimate;
        logic [15:0] out_location;
        logic [15:0] out_parent;
        logic [7:0]  out_obstacle;
        logic [6:0]  occupancy;
    } rsp_t;

endpackage

[rtl/sorted_priority_queue.sv]
// Channel | Direction | Handshake                      | Beat
// req     | in        | req_valid / req_stall          | spq_pkg::req_t
// rsp     | out       | rsp_valid / rsp_stall          | spq_pkg::rsp_t
//
// One operation at a time. Each entry visited is a read, then a compare or a
// write back. An insert moves larger entries up one from the tail, a pop and a
// remove shift the entries above down one, and a find or remove first searches
// from the head. Reset clears the state, the count and the output valid flag;
// the memory needs no clearing. A finished result waits in the output register
// while the next beat is accepted; the block holds in its last step only while
// that register is still full and stalled.
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  spq_pkg::req_t  req_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output spq_pkg::rsp_t  rsp_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = (CW > 7) ? CW : 7;
    localparam int EW = $bits(spq_pkg::entry_t);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_CHK  = 7'b0000100,
        S_WNEW = 7'b0001000,
        S_SRD  = 7'b0010000,
        S_SWR  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [AW-1:0]     addr_reg, addr_next;
    spq_pkg::req_t     req_reg, req_next;
    spq_pkg::entry_t   ent_reg, ent_next;
    logic [1:0]        stat_reg, stat_next;
    logic              rsp_valid_reg, rsp_valid_next;
    spq_pkg::rsp_t     rsp_reg, rsp_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [EW-1:0]     ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [EW-1:0]     ram_rdata;

    spq_pkg::entry_t   rd_ent;
    spq_pkg::entry_t   new_ent;
    logic              last_entry;
    logic              shift_end;
    logic              out_free;
    logic [OW-1:0]     occ_ext;

    spq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_ent      = spq_pkg::entry_t'(ram_rdata);
    assign new_ent.f   = req_reg.cost_total;
    assign new_ent.g   = req_reg.cost_so_far;
    assign new_ent.h   = req_reg.cost_estimate;
    assign new_ent.loc = req_reg.location;
    assign new_ent.par = req_reg.parent_location;
    assign new_ent.ob  = req_reg.obstacle_tag;

    // The entry at addr_reg is the last one held.
    assign last_entry = (CW'(addr_reg) + CW'(1)) >= cnt_reg;
    // After moving addr_reg + 1 down, nothing is left above it.
    assign shift_end  = (CW'(addr_reg) + CW'(2)) >= cnt_reg;
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign occ_ext    = OW'(cnt_reg);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // Reads and writes never touch the same entry in overlapping cycles: an
    // insert writes one slot above the one just read, a shift reads one slot
    // above the one it writes, so no forwarding is needed.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        addr_next      = addr_reg;
        req_next       = req_reg;
        ent_next       = ent_reg;
        stat_next      = stat_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = addr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next  = req_data;
                    ent_next  = '0;
                    stat_next = spq_pkg::STATUS_OK;
                    if (req_data.kind == spq_pkg::KIND_INSERT)
                    begin
                        if (cnt_reg == CW'(DEPTH))
                        begin
                            stat_next  = spq_pkg::STATUS_FULL;
                            state_next = S_DONE;
                        end
                        else if (cnt_reg == '0)
                        begin
                            addr_next  = '0;
                            state_next = S_WNEW;
                        end
                        else
                        begin
                            addr_next  = AW'(cnt_reg - CW'(1));
                            state_next = S_RD;
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        stat_next  = spq_pkg::STATUS_MISS;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        addr_next  = '0;
                        state_next = S_RD;
                    end
                end
            end

            S_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_CHK;
            end

            S_CHK:
            begin
                case (req_reg.kind)
                    spq_pkg::KIND_INSERT:
                    begin
                        // Walk down from the tail, moving larger keys up one.
                        if (rd_ent.f > req_reg.cost_total)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(addr_reg + AW'(1));
                            ram_wdata = rd_ent;
                            if (addr_reg == '0)
                            begin
                                state_next = S_WNEW;
                            end
                            else
                            begin
                                addr_next  = addr_reg - AW'(1);
                                state_next = S_RD;
                            end
                        end
                        else
                        begin
                            addr_next  = addr_reg + AW'(1);
                            state_next = S_WNEW;
                        end
                    end

                    spq_pkg::KIND_POP:
                    begin
                        ent_next = rd_ent;
                        if (last_entry)
                        begin
                            cnt_next   = cnt_reg - CW'(1);
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SRD;
                        end
                    end

                    default:
                    begin
                        if (rd_ent.loc == req_reg.location)
                        begin
                            ent_next = rd_ent;
                            if (req_reg.kind == spq_pkg::KIND_FIND)
                            begin
                                state_next = S_DONE;
                            end
                            else if (last_entry)
                            begin
                                cnt_next   = cnt_reg - CW'(1);
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SRD;
                            end
                        end
                        else if (last_entry)
                        begin
                            stat_next  = spq_pkg::STATUS_MISS;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            addr_next  = addr_reg + AW'(1);
                            state_next = S_RD;
                        end
                    end
                endcase
            end

            S_SRD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = addr_reg + AW'(1);
                state_next = S_SWR;
            end

            S_SWR:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = ram_rdata;
                addr_next = addr_reg + AW'(1);
                if (shift_end)
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SRD;
                end
            end

            S_WNEW:
            begin
                ram_we     = 1'b1;
                ram_waddr  = addr_reg;
                ram_wdata  = new_ent;
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next             = 1'b1;
                    rsp_next.status            = stat_reg;
                    rsp_next.out_cost_total    = ent_reg.f;
                    rsp_next.out_cost_so_far   = ent_reg.g;
                    rsp_next.out_cost_estimate = ent_reg.h;
                    rsp_next.out_location      = ent_reg.loc;
                    rsp_next.out_parent        = ent_reg.par;
                    rsp_next.out_obstacle      = ent_reg.ob;
                    rsp_next.occupancy         = occ_ext[6:0];
                    state_next                 = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        req_reg  <= req_next;
        ent_reg  <= ent_next;
        stat_reg <= stat_next;
        rsp_reg  <= rsp_next;
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != S_IDLE))
        else $error("accepted beat did not start an operation");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CHK || state_reg == S_SWR || state_reg == S_WNEW))
        else $error("memory written outside an operation");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free && stat_reg == spq_pkg::STATUS_FULL)
            |-> cnt_reg == CW'(DEPTH))
        else $error("full reported on a queue with room");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE || state_reg == S_RD)
            |=> $stable(cnt_reg))
        else $error("entry count changed outside an update step");
`endif

endmodule

[rtl/spq_ram.sv]
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
